// ----- rtl/egcd_pkg.sv -----
// Shared constants, types and width helpers for the extended GCD block.
`default_nettype none
package egcd_pkg;
  localparam int OperandWidth = 31;
  localparam int CoefWidth    = 32;
  localparam int DefaultWidth = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/extended_gcd.sv -----
// Extended Euclidean algorithm with a bit-serial divider and bit-serial multiply-subtract.
// Each Euclid step: a check state, then restoring division one quotient bit a cycle,
// then shift-subtract of both coefficients, one multiplier bit a cycle.
// One item at a time; the next item is taken once the result has moved to the output
// register. Typical operands need a handful of steps, worst case about 45 steps.
// Reset clears control state only; the block holds no state between items.
`default_nettype none
module extended_gcd
  import egcd_pkg::*;
#(
  parameter int WIDTH = DefaultWidth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // operand_a [30:0], operand_b [61:31], zeros [63:62]
  input  wire logic [63:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // gcd_value [30:0], coef_a [62:31], coef_b [94:63], zero [95]
  output logic [95:0]      m_tdata
);
  localparam int OB  = ((WIDTH - 1) < OperandWidth) ? (WIDTH - 1) : OperandWidth;
  localparam int CW  = WIDTH;
  localparam int CNW = $clog2(CW + 1);

  state_t state, state_next;

  logic [OB-1:0] r_prev, r_cur, quo, rem;
  logic [CW-1:0] s_prev, s_cur, t_prev, t_cur;
  logic [CW-1:0] qsh, acc_s, acc_t, s_mul, t_mul;
  logic [CNW-1:0] cnt;
  logic [OB:0]   trial;

  logic [OperandWidth-1:0] gcd_out;
  logic [CW-1:0]           sa_out, tb_out;
  logic                    out_full;

  assign trial = {rem, quo[OB-1]} - {1'b0, r_cur};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_CHECK;
      ST_CHECK: state_next = (r_cur == '0) ? ST_DONE : ST_DIV;
      ST_DIV:   if (cnt == CNW'(OB - 1)) state_next = ST_MUL;
      ST_MUL:   if (cnt == CNW'(CW - 1)) state_next = ST_CHECK;
      ST_DONE:  if (!out_full || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        r_prev <= s_tdata[OB-1:0];
        r_cur  <= s_tdata[31 +: OB];
        s_prev <= CW'(1);
        s_cur  <= '0;
        t_prev <= '0;
        t_cur  <= CW'(1);
      end
      ST_CHECK: begin
        // load dividend into the quotient shifter
        quo <= r_prev;
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        if (!trial[OB]) rem <= trial[OB-1:0];
        else            rem <= {rem[OB-2:0], quo[OB-1]};
        quo <= {quo[OB-2:0], ~trial[OB]};
        cnt <= cnt + CNW'(1);
        if (cnt == CNW'(OB - 1)) begin
          qsh   <= CW'({quo[OB-2:0], ~trial[OB]});
          s_mul <= s_cur;
          t_mul <= t_cur;
          acc_s <= s_prev;
          acc_t <= t_prev;
          cnt   <= '0;
        end
      end
      ST_MUL: begin
        // subtract one partial product per multiplier bit
        if (qsh[0]) begin
          acc_s <= acc_s - s_mul;
          acc_t <= acc_t - t_mul;
        end
        qsh   <= qsh >> 1;
        s_mul <= s_mul << 1;
        t_mul <= t_mul << 1;
        cnt   <= cnt + CNW'(1);
        if (cnt == CNW'(CW - 1)) begin
          r_prev <= r_cur;
          r_cur  <= rem;
          s_prev <= s_cur;
          t_prev <= t_cur;
          s_cur  <= qsh[0] ? acc_s - s_mul : acc_s;
          t_cur  <= qsh[0] ? acc_t - t_mul : acc_t;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (state == ST_DONE && (!out_full || m_tready)) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_full || m_tready)) begin
      gcd_out <= OperandWidth'(r_prev);
      sa_out  <= s_prev;
      tb_out  <= t_prev;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {1'b0, 32'(signed'(tb_out)), 32'(signed'(sa_out)), gcd_out};
endmodule
`default_nettype wire
